// File: hdl/gmdfs_pkg.sv
// ----------------------------------------------------------------------------
// Maze solver package
// Transaction types, command codes and register indexes shared by the
// depth-first maze solver core and its port checker.
// ----------------------------------------------------------------------------
package gmdfs_pkg;

  // command codes carried in the input transaction
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 4'd1;
  localparam int unsigned CFG_DATA_W = 7;

  // width of the solve epoch held in the visited memory
  localparam int unsigned EPOCH_W = 8;
  // compare width for bounds checks, covers coordinates up to 511
  localparam int unsigned CMP_W = 9;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [5:0]  goal_row;
    logic [5:0]  goal_col;
    logic        wall_right;
    logic        wall_below;
    logic [11:0] path_index;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [12:0] length;
    logic [5:0]  out_row;
    logic [5:0]  out_col;
    logic        index_error;
  } out_item_t;

endpackage

// File: hdl/grid_maze_dfs_path_finder_core.sv
// ----------------------------------------------------------------------------
// Depth-first maze solver core
// Loads wall bits per cell, runs a depth-first search over an explicit
// stack held in memory, and serves the stored path entry by entry.
// ----------------------------------------------------------------------------
// Results: a wall load answers from the output register; a path read first
//   passes the path memory read register and the S_RDW state.
// Flow: transactions are taken only when idle; a solve alternates a step (one
//   memory read) and a check per search step, then copies the path cell by cell,
//   as the wall, visited and stack memories have one read port. Reset: control
//   clears at once, then a pass wipes every visited entry, again before epoch wraps.
module grid_maze_dfs_path_finder_core #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  gmdfs_pkg::in_item_t                   in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output gmdfs_pkg::out_item_t                  out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [gmdfs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gmdfs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import gmdfs_pkg::*;

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned SPW   = $clog2(CELLS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);

  // sequencer state codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_STEP  = 4'd2;
  localparam logic [3:0] S_POPW  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_PTOP  = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PWR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_RDW   = 4'd9;

  // one frame of the search: cell and the next direction to try
  typedef struct packed {
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic [2:0]    dir;
  } frame_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [3:0]             state_q, state_d;
  logic [CFG_DATA_W-1:0]  rows_cfg_q, cols_cfg_q;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_data_q, out_data_d;
  logic                   found_q, found_d;
  logic [SPW-1:0]         len_q, len_d;
  logic [SPW-1:0]         sp_q, sp_d;
  logic [SPW-1:0]         pidx_q, pidx_d;
  logic [EPOCH_W-1:0]     epoch_q, epoch_d;
  logic [AW-1:0]          clr_q, clr_d;
  frame_t                 top_q, top_d;
  logic [5:0]             goal_row_q, goal_row_d, goal_col_q, goal_col_d;
  // neighbour under test, held from the step to the check cycle
  logic [RW-1:0]          nb_row_q, nb_row_d;
  logic [CW-1:0]          nb_col_q, nb_col_d;
  logic [AW-1:0]          nb_cell_q, nb_cell_d;
  logic                   nb_inb_q, nb_inb_d;
  logic                   nb_below_q, nb_below_d;

  // ---------------------------------------------------------------------------
  // Memories: wall bits, visited epochs, search stack, stored path
  // ---------------------------------------------------------------------------
  logic [1:0]         wall_mem  [CELLS];
  logic [EPOCH_W-1:0] vis_mem   [CELLS];
  frame_t             stk_mem   [CELLS];
  logic [11:0]        path_mem  [CELLS];

  logic               wall_we;
  logic [AW-1:0]      wall_waddr, wall_raddr;
  logic [1:0]         wall_wdata, wall_rd_q;
  logic               vis_we;
  logic [AW-1:0]      vis_waddr, vis_raddr;
  logic [EPOCH_W-1:0] vis_wdata, vis_rd_q;
  logic               stk_we;
  logic [AW-1:0]      stk_waddr, stk_raddr;
  frame_t             stk_wdata, stk_rd_q;
  logic               path_we;
  logic [AW-1:0]      path_waddr, path_raddr;
  logic [11:0]        path_wdata, path_rd_q;

  always_ff @(posedge clk_i) begin
    if (wall_we) begin
      wall_mem[wall_waddr] <= wall_wdata;
    end
    wall_rd_q <= wall_mem[wall_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rd_q <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (path_we) begin
      path_mem[path_waddr] <= path_wdata;
    end
    path_rd_q <= path_mem[path_raddr];
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic in_acc;

  // take a new transaction only when idle and the output register is free
  // or drains in this cycle
  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Bounds and addresses
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] rows_eff, cols_eff;
  logic             start_inb, start_is_goal, load_inb;
  logic [AW-1:0]    start_cell, load_cell, top_cell;
  logic [SPW-1:0]   sp_m1, sp_m2, pidx_m1;
  logic [RW-1:0]    nr;
  logic [CW-1:0]    nc;
  logic             inb, use_below;
  logic [AW-1:0]    wall_sel;
  logic             nb_open, nb_is_goal;

  // sizes above the storage act as the storage size
  assign rows_eff = (CMP_W'(rows_cfg_q) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS)
                                                             : CMP_W'(rows_cfg_q);
  assign cols_eff = (CMP_W'(cols_cfg_q) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS)
                                                             : CMP_W'(cols_cfg_q);

  assign start_inb     = (CMP_W'(in_data_i.cell_row) < rows_eff) &&
                         (CMP_W'(in_data_i.cell_col) < cols_eff);
  assign start_is_goal = (in_data_i.cell_row == in_data_i.goal_row) &&
                         (in_data_i.cell_col == in_data_i.goal_col);
  assign load_inb      = (CMP_W'(in_data_i.cell_row) < CMP_W'(MAX_ROWS)) &&
                         (CMP_W'(in_data_i.cell_col) < CMP_W'(MAX_COLS));

  assign start_cell = AW'(in_data_i.cell_row) * AW'(MAX_COLS) + AW'(in_data_i.cell_col);
  assign load_cell  = start_cell;
  assign top_cell   = AW'(top_q.row) * AW'(MAX_COLS) + AW'(top_q.col);

  assign sp_m1   = sp_q - SPW'(1);
  assign sp_m2   = sp_q - SPW'(2);
  assign pidx_m1 = pidx_q - SPW'(1);

  // neighbour in the current direction: right, down, left, up
  always_comb begin
    nr        = top_q.row;
    nc        = top_q.col;
    inb       = 1'b0;
    use_below = 1'b0;
    wall_sel  = top_cell;
    unique case (top_q.dir[1:0])
      2'd0: begin
        nc  = top_q.col + CW'(1);
        inb = (CMP_W'(top_q.col) + CMP_W'(1)) < cols_eff;
      end
      2'd1: begin
        nr        = top_q.row + RW'(1);
        inb       = (CMP_W'(top_q.row) + CMP_W'(1)) < rows_eff;
        use_below = 1'b1;
      end
      2'd2: begin
        nc       = top_q.col - CW'(1);
        inb      = (top_q.col != '0);
        wall_sel = top_cell - AW'(1);
      end
      default: begin
        nr        = top_q.row - RW'(1);
        inb       = (top_q.row != '0);
        use_below = 1'b1;
        wall_sel  = top_cell - AW'(MAX_COLS);
      end
    endcase
  end

  assign nb_open    = nb_inb_q && !(nb_below_q ? wall_rd_q[1] : wall_rd_q[0]);
  assign nb_is_goal = (CMP_W'(nb_row_q) == CMP_W'(goal_row_q)) &&
                      (CMP_W'(nb_col_q) == CMP_W'(goal_col_q));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    found_d     = found_q;
    len_d       = len_q;
    sp_d        = sp_q;
    pidx_d      = pidx_q;
    epoch_d     = epoch_q;
    clr_d       = clr_q;
    top_d       = top_q;
    goal_row_d  = goal_row_q;
    goal_col_d  = goal_col_q;
    nb_row_d    = nb_row_q;
    nb_col_d    = nb_col_q;
    nb_cell_d   = nb_cell_q;
    nb_inb_d    = nb_inb_q;
    nb_below_d  = nb_below_q;

    wall_we    = 1'b0;
    wall_waddr = load_cell;
    wall_wdata = {in_data_i.wall_below, in_data_i.wall_right};
    wall_raddr = wall_sel;
    vis_we     = 1'b0;
    vis_waddr  = nb_cell_q;
    vis_wdata  = epoch_q;
    vis_raddr  = AW'(nr) * AW'(MAX_COLS) + AW'(nc);
    stk_we     = 1'b0;
    stk_waddr  = sp_m1[AW-1:0];
    stk_wdata  = top_q;
    stk_raddr  = sp_m2[AW-1:0];
    path_we    = 1'b0;
    path_waddr = len_q[AW-1:0];
    path_wdata = {6'(top_q.row), 6'(top_q.col)};
    path_raddr = AW'(in_data_i.path_index);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.cmd)
            CMD_SOLVE: begin
              found_d    = 1'b0;
              len_d      = '0;
              sp_d       = '0;
              goal_row_d = in_data_i.goal_row;
              goal_col_d = in_data_i.goal_col;
              state_d    = S_DONE;
              if (start_is_goal) begin
                // start equals goal wins over the bounds check
                path_we    = 1'b1;
                path_waddr = '0;
                path_wdata = {in_data_i.cell_row, in_data_i.cell_col};
                len_d      = SPW'(1);
                found_d    = 1'b1;
              end else if (start_inb) begin
                epoch_d   = epoch_q + EPOCH_W'(1);
                vis_we    = 1'b1;
                vis_waddr = start_cell;
                vis_wdata = epoch_d;
                top_d     = '{row: RW'(in_data_i.cell_row),
                              col: CW'(in_data_i.cell_col), dir: 3'd0};
                sp_d      = SPW'(1);
                state_d   = S_STEP;
              end
            end
            CMD_READ: begin
              if (SPW'(in_data_i.path_index) < len_q &&
                  (SPW >= 12 || in_data_i.path_index < 12'(CELLS))) begin
                state_d = S_RDW;
              end else begin
                out_valid_d = 1'b1;
                out_data_d  = '{found: found_q, length: 13'(len_q),
                                out_row: '0, out_col: '0, index_error: 1'b1};
              end
            end
            default: begin
              // load, and the unused code answers like a load
              if (in_data_i.cmd == CMD_LOAD && load_inb) begin
                wall_we = 1'b1;
              end
              out_valid_d = 1'b1;
              out_data_d  = '{found: found_q, length: 13'(len_q),
                              out_row: '0, out_col: '0, index_error: 1'b0};
            end
          endcase
        end
      end
      S_RDW: begin
        out_valid_d = 1'b1;
        out_data_d  = '{found: found_q, length: 13'(len_q), out_row: path_rd_q[11:6],
                        out_col: path_rd_q[5:0], index_error: 1'b0};
        state_d     = S_IDLE;
      end
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(CELLS - 1)) begin
          clr_d   = '0;
          epoch_d = '0;
          state_d = S_IDLE;
        end
      end
      S_STEP: begin
        if (top_q.dir[2]) begin
          // every direction tried: drop the frame
          sp_d = sp_m1;
          if (sp_q == SPW'(1)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_POPW;
          end
        end else begin
          // fetch wall and visited mark of the neighbour
          top_d.dir  = top_q.dir + 3'd1;
          nb_row_d   = nr;
          nb_col_d   = nc;
          nb_cell_d  = AW'(nr) * AW'(MAX_COLS) + AW'(nc);
          nb_inb_d   = inb;
          nb_below_d = use_below;
          state_d    = S_CHECK;
        end
      end
      S_POPW: begin
        top_d   = stk_rd_q;
        state_d = S_STEP;
      end
      S_CHECK: begin
        state_d = S_STEP;
        if (nb_open) begin
          if (nb_is_goal) begin
            path_we    = 1'b1;
            path_waddr = '0;
            path_wdata = {6'(nb_row_q), 6'(nb_col_q)};
            len_d      = SPW'(1);
            found_d    = 1'b1;
            state_d    = S_PTOP;
          end else if (vis_rd_q != epoch_q && sp_q < SPW'(CELLS)) begin
            vis_we = 1'b1;
            stk_we = 1'b1;
            top_d  = '{row: nb_row_q, col: nb_col_q, dir: 3'd0};
            sp_d   = sp_q + SPW'(1);
          end
        end
      end
      S_PTOP: begin
        path_we = 1'b1;
        len_d   = len_q + SPW'(1);
        pidx_d  = sp_m1;
        state_d = S_PRD;
      end
      S_PRD: begin
        stk_raddr = pidx_m1[AW-1:0];
        if (pidx_q == '0) begin
          sp_d    = '0;
          state_d = S_DONE;
        end else begin
          pidx_d  = pidx_m1;
          state_d = S_PWR;
        end
      end
      S_PWR: begin
        path_we    = 1'b1;
        path_wdata = {6'(stk_rd_q.row), 6'(stk_rd_q.col)};
        len_d      = len_q + SPW'(1);
        state_d    = S_PRD;
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        out_data_d  = '{found: found_q, length: 13'(len_q),
                        out_row: '0, out_col: '0, index_error: 1'b0};
        // wipe the visited memory before the epoch wraps
        state_d     = (epoch_q == '1) ? S_CLEAR : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rows_cfg_q  <= CFG_DATA_W'(64);
      cols_cfg_q  <= CFG_DATA_W'(64);
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      len_q       <= '0;
      sp_q        <= '0;
      pidx_q      <= '0;
      epoch_q     <= '0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      len_q       <= len_d;
      sp_q        <= sp_d;
      pidx_q      <= pidx_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      if (cfg_valid_i && cfg_index_i == CFG_ROWS) begin
        rows_cfg_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CFG_COLS) begin
        cols_cfg_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    top_q      <= top_d;
    goal_row_q <= goal_row_d;
    goal_col_q <= goal_col_d;
    nb_row_q   <= nb_row_d;
    nb_col_q   <= nb_col_d;
    nb_cell_q  <= nb_cell_d;
    nb_inb_q   <= nb_inb_d;
    nb_below_q <= nb_below_d;
  end

endmodule

// File: hdl/gmdfs_checker.sv
// ----------------------------------------------------------------------------
// Maze solver port checker
// Watches the transaction ports of the solver core over time.
// ----------------------------------------------------------------------------
module gmdfs_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input gmdfs_pkg::out_item_t out_data_o
);
  import gmdfs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a found path always has cells, a failed solve none
  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.found == (out_data_o.length != 13'd0)))
    else $error("found flag and length disagree");

  // a failed read carries no cell
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.index_error |->
      out_data_o.out_row == 6'd0 && out_data_o.out_col == 6'd0)
    else $error("index error with cell data");

  // no new transaction while a result is stalled
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result stalled");

endmodule

bind grid_maze_dfs_path_finder_core gmdfs_checker u_gmdfs_checker (.*);

// File: verif/tb_grid_maze_dfs_path_finder_core.sv
// ----------------------------------------------------------------------------
// Maze solver core testbench
// Loads a walled-in corner region of the wall store, then runs directed and
// random load, solve and path read transactions over a series of maze sizes.
// A local depth-first search predicts every result, which is checked field by
// field in order.
// ----------------------------------------------------------------------------
module tb_grid_maze_dfs_path_finder_core;
  import gmdfs_pkg::*;

  localparam int GRID = 64;
  localparam int CELLS = GRID * GRID;
  // corner region that is always loaded; its last column keeps a right wall
  // and its last row a below wall, so no search inside it ever leaves it
  localparam int REGION = 32;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int LONG_HOLD = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  grid_maze_dfs_path_finder_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Shadow state of the solver
  logic [1:0] wall_mem [CELLS];
  bit seen_map [CELLS];
  int stk_cell [CELLS];
  int stk_dir [CELLS];
  int trail_row [CELLS+1];
  int trail_col [CELLS+1];
  int trail_len = 0;
  bit trail_found = 1'b0;
  logic [6:0] rows_reg = 7'd64;
  logic [6:0] cols_reg = 7'd64;

  in_item_t pending_q[$];
  out_item_t answer_q[$];

  int fail_count = 0;
  int solve_count = 0;
  int found_count = 0;
  int index_err_count = 0;
  int accepted_count = 0;
  bit idle_off = 1'b0;
  bit long_hold_req = 1'b0;
  int idle_cycles = 0;

  function automatic void add_trail(int r, int c);
    if (trail_len <= CELLS) begin
      trail_row[trail_len] = r;
      trail_col[trail_len] = c;
      trail_len++;
    end
  endfunction

  // Depth-first search: right, down, left, up; goal tested before bounds
  function automatic void search_maze(int sr, int sc, int gr, int gc);
    int rows, cols, sp, top, here, r, c, d, nr, nc, k;
    bit open;
    rows = (rows_reg > GRID) ? GRID : int'(rows_reg);
    cols = (cols_reg > GRID) ? GRID : int'(cols_reg);
    for (k = 0; k < CELLS; k++) seen_map[k] = 1'b0;
    trail_len = 0;
    trail_found = 1'b0;
    if (sr == gr && sc == gc) begin
      add_trail(sr, sc);
      trail_found = 1'b1;
      return;
    end
    if (sr >= rows || sc >= cols) return;
    seen_map[sr*GRID+sc] = 1'b1;
    stk_cell[0] = sr*GRID + sc;
    stk_dir[0] = 0;
    sp = 1;
    while (sp > 0) begin
      top = sp - 1;
      here = stk_cell[top];
      r = here / GRID;
      c = here % GRID;
      d = stk_dir[top];
      nr = r;
      nc = c;
      if (d >= 4) begin
        sp--;
        continue;
      end
      stk_dir[top] = d + 1;
      case (d)
        0: begin open = (c + 1 < cols) && !wall_mem[here][0]; nc = c + 1; end
        1: begin open = (r + 1 < rows) && !wall_mem[here][1]; nr = r + 1; end
        2: begin open = (c > 0) && !wall_mem[here-1][0]; nc = c - 1; end
        default: begin open = (r > 0) && !wall_mem[here-GRID][1]; nr = r - 1; end
      endcase
      if (!open) continue;
      if (nr == gr && nc == gc) begin
        add_trail(nr, nc);
        for (k = sp; k > 0; k--) add_trail(stk_cell[k-1] / GRID, stk_cell[k-1] % GRID);
        trail_found = 1'b1;
        return;
      end
      if (!seen_map[nr*GRID+nc] && sp < CELLS) begin
        seen_map[nr*GRID+nc] = 1'b1;
        stk_cell[sp] = nr*GRID + nc;
        stk_dir[sp] = 0;
        sp++;
      end
    end
  endfunction

  function automatic out_item_t maze_answer(in_item_t it);
    out_item_t res;
    res = '0;
    case (it.cmd)
      CMD_LOAD: wall_mem[it.cell_row*GRID+it.cell_col] = {it.wall_below, it.wall_right};
      CMD_SOLVE: begin
        search_maze(int'(it.cell_row), int'(it.cell_col), int'(it.goal_row),
                    int'(it.goal_col));
        solve_count++;
        if (trail_found) found_count++;
      end
      CMD_READ: begin
        if (it.path_index < trail_len) begin
          res.out_row = trail_row[it.path_index][5:0];
          res.out_col = trail_col[it.path_index][5:0];
        end else begin
          res.index_error = 1'b1;
          index_err_count++;
        end
      end
      default: ;
    endcase
    res.found = trail_found;
    res.length = trail_len[12:0];
    return res;
  endfunction

  // Driver: predict on acceptance, hold a stalled transaction, idle in bursts
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        answer_q.push_back(maze_answer(in_data_i));
        accepted_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare against the oldest expectation, drive stall
  int hold_left = 0;
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_o);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (out_data_o.found !== want.found) begin
            $display("%0t: found exp %0d got %0d", $time, want.found, out_data_o.found);
            fail_count++;
          end
          if (out_data_o.length !== want.length) begin
            $display("%0t: length exp %0d got %0d", $time, want.length, out_data_o.length);
            fail_count++;
          end
          if (out_data_o.out_row !== want.out_row) begin
            $display("%0t: out_row exp %0d got %0d", $time, want.out_row,
                     out_data_o.out_row);
            fail_count++;
          end
          if (out_data_o.out_col !== want.out_col) begin
            $display("%0t: out_col exp %0d got %0d", $time, want.out_col,
                     out_data_o.out_col);
            fail_count++;
          end
          if (out_data_o.index_error !== want.index_error) begin
            $display("%0t: index_error exp %0d got %0d", $time, want.index_error,
                     out_data_o.index_error);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_stall_i <= 1'b1;
      end else if (!idle_off && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("tb_grid_maze_dfs_path_finder_core NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ROWS) rows_reg = val;
    else if (idx == CFG_COLS) cols_reg = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || answer_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic in_item_t make_op(logic [1:0] op, int r, int c, int gr, int gc,
                                       int wr, int wb, int idx);
    in_item_t it;
    it.cmd = op;
    it.cell_row = 6'(r);
    it.cell_col = 6'(c);
    it.goal_row = 6'(gr);
    it.goal_col = 6'(gc);
    it.wall_right = 1'(wr);
    it.wall_below = 1'(wb);
    it.path_index = 12'(idx);
    return it;
  endfunction

  function automatic int pick_coord(int lim);
    if (lim == 0 || $urandom_range(0, 99) < 12) return $urandom_range(0, GRID - 1);
    return $urandom_range(0, lim - 1);
  endfunction

  // Random mix; solves per phase set by solve_pct so large mazes stay quick.
  // Starts inside the maze stay in the loaded region, and loads on its edge
  // keep the enclosing walls.
  task automatic add_random(int n, int solve_pct);
    int k, pick, lr, lc, r, c, gr, gc, idx;
    in_item_t it;
    lr = (rows_reg > GRID) ? GRID : int'(rows_reg);
    lc = (cols_reg > GRID) ? GRID : int'(cols_reg);
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      r = pick_coord(lr);
      c = pick_coord(lc);
      gr = pick_coord(lr);
      gc = pick_coord(lc);
      if (r < lr && c < lc && (r >= REGION || c >= REGION)) begin
        r = r % REGION;
        c = c % REGION;
      end
      if ($urandom_range(0, 19) == 0) begin gr = r; gc = c; end
      case ($urandom_range(0, 9))
        0: idx = $urandom_range(0, 4095);
        1: idx = $urandom_range(0, 300);
        default: idx = $urandom_range(0, 20);
      endcase
      it = make_op(CMD_LOAD, r, c, gr, gc,
                   (c == REGION - 1) || ($urandom_range(0, 9) < 3),
                   (r == REGION - 1) || ($urandom_range(0, 9) < 3), idx);
      if (pick < solve_pct) it.cmd = CMD_SOLVE;
      else if (pick < solve_pct + 35) it.cmd = CMD_READ;
      else if (pick >= 96) it.cmd = 2'd3;
      pending_q.push_back(it);
    end
  endtask

  initial begin
    int k, rows_v, cols_v;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load the walled-in region so no search can touch an unloaded cell
    for (k = 0; k < REGION * REGION; k++)
      pending_q.push_back(make_op(CMD_LOAD, k / REGION, k % REGION, 0, 0,
                                  (k % REGION == REGION - 1) || ($urandom_range(0, 9) < 3),
                                  (k / REGION == REGION - 1) || ($urandom_range(0, 9) < 3),
                                  0));
    drain();

    // Directed: corners, full-width fields, spare command, reads past the end
    pending_q.push_back(make_op(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_op(CMD_LOAD, 63, 63, 63, 63, 1, 1, 4095));
    pending_q.push_back(make_op(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_op(CMD_SOLVE, 5, 5, 5, 5, 0, 0, 0));
    pending_q.push_back(make_op(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_op(CMD_READ, 0, 0, 0, 0, 0, 0, 1));
    pending_q.push_back(make_op(CMD_SOLVE, 0, 0, 63, 63, 0, 0, 0));
    pending_q.push_back(make_op(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_op(CMD_READ, 0, 0, 0, 0, 0, 0, 4095));
    pending_q.push_back(make_op(2'd3, 63, 63, 63, 63, 1, 1, 4095));
    pending_q.push_back(make_op(CMD_SOLVE, 31, 0, 0, 31, 0, 0, 0));
    pending_q.push_back(make_op(CMD_READ, 0, 0, 0, 0, 0, 0, 2));
    drain();

    // Tiny maze: start outside, goal outside, start equals goal outside
    write_reg(CFG_ROWS, 7'd3);
    write_reg(CFG_COLS, 7'd7);
    write_reg(CFG_UNUSED, 7'd1);
    pending_q.push_back(make_op(CMD_SOLVE, 5, 0, 0, 1, 0, 0, 0));
    pending_q.push_back(make_op(CMD_SOLVE, 0, 0, 0, 9, 0, 0, 0));
    pending_q.push_back(make_op(CMD_SOLVE, 40, 40, 40, 40, 0, 0, 0));
    pending_q.push_back(make_op(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_op(CMD_SOLVE, 0, 0, 2, 6, 0, 0, 0));
    pending_q.push_back(make_op(CMD_READ, 0, 0, 0, 0, 0, 0, 1));
    drain();

    // Zero-sized maze, then a burst behind a long receiver hold-off
    write_reg(CFG_ROWS, 7'd0);
    write_reg(CFG_COLS, 7'd5);
    long_hold_req = 1'b1;
    add_random(80, 25);
    drain();

    for (k = 0; k < 20; k++) begin
      case (k)
        0: begin rows_v = 1; cols_v = 1; end
        1: begin rows_v = 127; cols_v = 127; end
        2: begin rows_v = 64; cols_v = 2; end
        3: begin rows_v = 2; cols_v = 64; end
        4: begin rows_v = 1; cols_v = 64; end
        default: begin
          rows_v = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 10);
          cols_v = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 10);
        end
      endcase
      if (k == 19) idle_off = 1'b1;
      write_reg(CFG_ROWS, 7'(rows_v));
      write_reg(CFG_COLS, 7'(cols_v));
      add_random(45, (rows_v * cols_v > 256) ? 2 : 25);
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("Covered %0d transactions, %0d solves (%0d found), %0d out-of-range reads",
             accepted_count, solve_count, found_count, index_err_count);
    $display("over mazes from empty to full size, with stalls and a long hold-off.");
    if (fail_count == 0) begin
      $display("tb_grid_maze_dfs_path_finder_core OK");
    end else begin
      $display("tb_grid_maze_dfs_path_finder_core NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/gmdfs_pkg.sv
hdl/grid_maze_dfs_path_finder_core.sv
hdl/gmdfs_checker.sv
verif/tb_grid_maze_dfs_path_finder_core.sv
